FILE: hdl/isrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isrt_pkg;

    // width of one stored value
    localparam int DATA_W = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the accepted item, start position at fill count
        logic drop;       // store full: flag the dropped value
        logic read_prev;  // read the entry just below the insert position
        logic shift;      // move the read entry up one place
        logic place;      // write the new value at the insert position
        logic k_clr;      // restart the output index
        logic read_k;     // read the entry at the output index
        logic load_out;   // capture read data into the output register
        logic k_inc;      // step the output index
        logic clear;      // empty the store after the run
    } isrt_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;       // store holds the maximum number of values
        logic pos_zero;   // insert position is the bottom of the store
        logic greater;    // read entry is greater than the new value
        logic end_flag;   // accepted item closes the set
        logic last_out;   // output index points at the top entry
    } isrt_status_t;

endpackage

`default_nettype wire

FILE: hdl/isrt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module isrt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire isrt_pkg::isrt_status_t status,
    output isrt_pkg::isrt_cmd_t        cmd
);
    import isrt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (status.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_DONE;
                end
                else if (status.pos_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.read_prev = 1'b1;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                if (status.greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_START;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.end_flag)
                begin
                    cmd.k_clr  = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.read_k = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_out = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    if (status.last_out)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/isrt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module isrt_datapath #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [isrt_pkg::DATA_W-1:0] in_value,
    input  wire logic                          in_end,
    input  wire isrt_pkg::isrt_cmd_t           cmd,
    output isrt_pkg::isrt_status_t             status,
    output logic signed [isrt_pkg::DATA_W-1:0] out_value,
    output logic                               out_last,
    output logic                               out_ovf
);
    import isrt_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LEN);

    logic signed [DATA_W-1:0] mem [MAX_LEN];

    logic [CW-1:0]            fill_reg;
    logic                     dropped_reg;
    logic [AW-1:0]            pos_reg;
    logic [AW-1:0]            k_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic                     end_reg;
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;
    logic                     out_ovf_reg;

    logic [AW-1:0]            raddr;
    logic                     wen;
    logic signed [DATA_W-1:0] wdata;

    // memory ports
    assign raddr = cmd.read_k ? k_reg : (pos_reg - 1'b1);
    assign wen   = cmd.shift | cmd.place;
    assign wdata = cmd.shift ? rdata_reg : val_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[pos_reg] <= wdata;
        end
        if (cmd.read_prev | cmd.read_k)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
            pos_reg     <= '0;
            k_reg       <= '0;
            end_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                pos_reg <= fill_reg[AW-1:0];
                end_reg <= in_end;
            end
            else if (cmd.shift)
            begin
                pos_reg <= pos_reg - 1'b1;
            end
            if (cmd.drop)
            begin
                dropped_reg <= 1'b1;
            end
            if (cmd.clear)
            begin
                fill_reg    <= '0;
                dropped_reg <= 1'b0;
            end
            else if (cmd.place)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.k_clr)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // item value and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= in_value;
        end
        if (cmd.load_out)
        begin
            out_value_reg <= rdata_reg;
            out_last_reg  <= status.last_out;
            out_ovf_reg   <= dropped_reg;
        end
    end

    // status back to the controller
    always_comb
    begin
        status.full     = (fill_reg == FULL_CNT);
        status.pos_zero = (pos_reg == '0);
        status.greater  = (rdata_reg > val_reg);
        status.end_flag = end_reg;
        status.last_out = ((CW'(k_reg) + 1'b1) == fill_reg);
    end

    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

`default_nettype wire

FILE: hdl/insertion_sorter_top.sv
// input side: an accepted item keeps the input closed through START, then a CMP and a shift back to
// START for each stored value greater than it, then the place and DONE; at the bottom or dropped it skips CMP
// one item at a time; each shift step reads the store memory in START and writes it in CMP,
// the memory having a single registered read port
// a closing item then gives its results in order, each through RD, LOAD and OUT; OUT waits for ready
// reset: rst_n clears the fill count, drop flag and controller; store contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter_top #(
    parameter int MAX_LEN = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,   // end_of_set
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,   // last_of_run
    output logic [0:0]       m_tuser    // [0] overflow
);
    import isrt_pkg::*;

    isrt_cmd_t                cmd;
    isrt_status_t             status;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_last;
    logic                     out_ovf;

    // sequencer
    isrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // store, counters and output register
    isrt_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_value  ($signed(s_tdata)),
        .in_end    (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_value (out_value),
        .out_last  (out_last),
        .out_ovf   (out_ovf)
    );

    assign m_tdata    = out_value;
    assign m_tlast    = out_last;
    assign m_tuser[0] = out_ovf;

    // input and output sides are never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // an accepted item closes the input side for the insert walk
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready straight after accepting an item");

    // the final result of a run returns the block to idle
    a_idle_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not idle after last result");

    // a result that is not last is followed by a gap before the next one
    a_gap_between: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid && !s_tready))
        else $error("run broken off before its last result");

endmodule

`default_nettype wire

FILE: tb/insertion_sorter_top_test.sv
`timescale 1ns / 1ps

module insertion_sorter_top_test;

    import isrt_pkg::DATA_W;

    localparam int MAX_LEN     = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 3 * MAX_LEN + 150;
    localparam int RANDOM_ITEMS = 90;

    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

    // one emitted element of a sorted run
    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last_of_run;
        logic              overflow;
    } sorted_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;   // [31:0] value
    logic              s_tlast = 1'b0; // end_of_set
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;        // [31:0] sorted_value
    logic              m_tlast;        // last_of_run
    logic [0:0]        m_tuser;        // [0] overflow

    // shadow copy of the sorter state
    logic signed [DATA_W-1:0] shadow_store[$];
    logic                     shadow_dropped = 1'b0;
    sorted_result_t           pending_results[$];

    bit          idle_en = 1'b0;
    int          stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned sets_sent = 0;
    int unsigned results_seen = 0;
    int unsigned overflow_sets = 0;

    insertion_sorter_top #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // downstream ready with random stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // compare each emitted item with the oldest expected one
    always @(posedge clk)
    begin
        sorted_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d last_of_run %0b overflow %0b",
                       $signed(m_tdata), m_tlast, m_tuser[0]);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value)
                begin
                    $error("sorted_value: expected %0d, actual %0d",
                           $signed(want.value), $signed(m_tdata));
                    fail_count++;
                end
                if (m_tlast !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, actual %0b", want.last_of_run, m_tlast);
                    fail_count++;
                end
                if (m_tuser[0] !== want.overflow)
                begin
                    $error("overflow: expected %0b, actual %0b", want.overflow, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // insert one accepted value and queue the run when the set closes
    task automatic insert_and_emit(input logic [DATA_W-1:0] value, input logic end_mark);
        int             pos;
        sorted_result_t res;
        pos = shadow_store.size();
        if (pos >= MAX_LEN)
        begin
            shadow_dropped = 1'b1;
        end
        else
        begin
            // land after every stored value less than or equal to the new one
            while (pos > 0 && shadow_store[pos-1] > $signed(value))
                pos--;
            shadow_store.insert(pos, $signed(value));
        end
        if (end_mark)
        begin
            sets_sent++;
            if (shadow_dropped)
                overflow_sets++;
            foreach (shadow_store[k])
            begin
                res.value       = shadow_store[k];
                res.last_of_run = (k == shadow_store.size() - 1);
                res.overflow    = shadow_dropped;
                pending_results.push_back(res);
            end
            shadow_store.delete();
            shadow_dropped = 1'b0;
        end
    endtask

    // offer one item and wait for it to be taken
    task automatic send_item(input logic [DATA_W-1:0] value, input logic end_mark);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= end_mark;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        insert_and_emit(value, end_mark);
    endtask

    // random value, biased towards extremes and repeats
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VAL_MAX - $urandom_range(0, 2);
            1: v = VAL_MIN + $urandom_range(0, 2);
            2, 3: v = $urandom_range(0, 15) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // send a set of random values of the given length
    task automatic send_random_set(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1);
    endtask

    // single-element sets at the extremes and zero
    task automatic test_single_sets();
        idle_en = 1'b0;
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MIN, 1'b1);
        send_item('0, 1'b1);
    endtask

    // extremes of the value range and bit patterns
    task automatic test_extremes();
        logic [DATA_W-1:0] vals[9];
        vals = '{VAL_MAX, VAL_MIN, 32'd0, 32'hFFFF_FFFF, 32'd1,
                 32'h5555_5555, 32'hAAAA_AAAA, VAL_MIN, VAL_MAX};
        idle_en = 1'b1;
        foreach (vals[i])
            send_item(vals[i], i == 8);
    endtask

    // descending input forces the longest shift walks, repeats test stable order
    task automatic test_descending_and_repeats();
        for (int i = 5; i >= 1; i--)
            send_item(i, i == 1);
        send_item(32'd7, 1'b0);
        send_item(32'd7, 1'b0);
        send_item(-32'sd3, 1'b0);
        send_item(32'd7, 1'b0);
        send_item(-32'sd3, 1'b1);
    endtask

    // exactly full set, then a set dropping several items, the last one closing
    task automatic test_full_store();
        idle_en = 1'b1;
        send_random_set(MAX_LEN);
        for (int i = 0; i < MAX_LEN + 3; i++)
            send_item(pick_value(), 1'b0);
        send_item(VAL_MIN, 1'b1);
    endtask

    // random sets, mostly short, now and then near, at or past the store size
    task automatic test_random_sets();
        int unsigned start;
        int          len;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            idle_en = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
                1, 2, 3: len = $urandom_range(9, 24);
                default: len = $urandom_range(1, 8);
            endcase
            send_random_set(len);
        end
    endtask

    // back-to-back items and a ready receiver
    task automatic test_no_idle();
        idle_en = 1'b0;
        repeat (6) send_random_set($urandom_range(1, 8));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sets();
        test_extremes();
        test_descending_and_repeats();
        test_full_store();
        test_random_sets();
        test_no_idle();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d items in %0d sets, %0d of them overflowing the store",
                 items_sent, sets_sent, overflow_sets);
        $display("checked %0d sorted results in %0d cycles", results_seen, cycle_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
